### hw/rtl/smt_pkg.sv
// Shared types and constants for the sorted multimap table.
package smt_pkg;

	localparam int DEPTH       = 32;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int RES_LIMIT   = 32;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int POS_W = 6;

	typedef enum logic [2:0] {
		KIND_INSERT = 3'd0,
		KIND_FIND   = 3'd1,
		KIND_RANGE  = 3'd2,
		KIND_READ   = 3'd3,
		KIND_CLEAR  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_PAST_END  = 2'd3
	} status_t;

endpackage

### hw/rtl/sorted_multimap_table.sv
// Sorted key/value table with insert, find, equal range, positional read and clear.
//
// Input channel (in_valid / in_stall) carries one operation per item: kind, key,
// value and position. Output channel (out_valid / out_stall) carries result items:
// status, lower and upper bound, entry key/value, entry count and a last mark.
// Entries sit in one synchronous memory with one read and one write port (registered read).
// One item is worked on at a time; in_stall is high while an item is in flight.
// Insert, find and equal range first scan the table one entry per cycle to
// count the lower and upper bound. Insert then moves the entries at and
// above the lower bound up, each read in S_SHIFT_RD and written in S_SHIFT_WR,
// and writes the new entry in S_INS_WR. Find and positional read add a memory
// read through S_READ and S_FETCH; equal range emits one result per match, each
// read the same way once the previous one is taken. Clear and unknown kinds
// answer straight from the accept. After reset the table is empty and no result
// is pending; the memory contents need no clearing. A stalled result holds in
// the output register until taken, and no new item is accepted meanwhile.
module sorted_multimap_table (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           kind,
	input  logic signed [31:0]                   key,
	input  logic [31:0]                          value,
	input  logic [4:0]                           position,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [smt_pkg::POS_W-1:0]            lower_pos,
	output logic [smt_pkg::POS_W-1:0]            upper_pos,
	output logic signed [31:0]                   entry_key,
	output logic [31:0]                          entry_value,
	output logic [smt_pkg::POS_W-1:0]            entry_count,
	output logic                                 last
);

	localparam int AW = smt_pkg::AW;
	localparam int CW = smt_pkg::CW;
	localparam int KW = smt_pkg::KEY_WIDTH;
	localparam int VW = smt_pkg::VALUE_WIDTH;
	localparam int PW = smt_pkg::POS_W;
	localparam int DEPTH_C     = smt_pkg::DEPTH;
	localparam int RES_LIMIT_C = smt_pkg::RES_LIMIT;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_POST, S_SHIFT_RD, S_SHIFT_WR, S_INS_WR, S_READ, S_FETCH, S_OUT
	} state_t;

	state_t                  state_q;
	logic [2:0]              kind_q;
	logic signed [KW-1:0]    key_q;
	logic [VW-1:0]           value_q;
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           end_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hi_q;
	logic [CW-1:0]           sh_q;
	logic                    rv_s1;

	logic                    out_valid_q;
	logic [1:0]              status_q;
	logic [PW-1:0]           lower_q;
	logic [PW-1:0]           upper_q;
	logic signed [31:0]      ekey_q;
	logic [31:0]             evalue_q;
	logic [PW-1:0]           count_q;
	logic                    last_q;

	// entry memory
	logic [KW+VW-1:0]        mem [DEPTH_C];
	logic [KW+VW-1:0]        rd_q;
	logic [AW-1:0]           raddr;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic [KW+VW-1:0]        wdata;

	logic signed [KW-1:0]    rd_key;
	logic [VW-1:0]           rd_value;
	logic [CW-1:0]           span;
	logic [CW-1:0]           pos_ext;

	assign rd_key   = rd_q[KW+VW-1:VW];
	assign rd_value = rd_q[VW-1:0];
	assign span     = hi_q - lo_q;
	assign pos_ext  = CW'(position);

	// pick memory addresses for the current step
	always_comb begin
		raddr = idx_q[AW-1:0];
		we    = 1'b0;
		waddr = sh_q[AW-1:0];
		wdata = rd_q;
		unique case (state_q)
			S_SHIFT_RD: raddr = AW'(sh_q - CW'(1));
			S_SHIFT_WR: begin
				we = 1'b1;
			end
			S_INS_WR: begin
				we    = 1'b1;
				waddr = lo_q[AW-1:0];
				wdata = {key_q, value_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= '0;
			key_q       <= '0;
			value_q     <= '0;
			idx_q       <= '0;
			end_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			sh_q        <= '0;
			status_q    <= '0;
			lower_q     <= '0;
			upper_q     <= '0;
			ekey_q      <= '0;
			evalue_q    <= '0;
			count_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						key_q   <= key[KW-1:0];
						value_q <= value[VW-1:0];
						idx_q   <= '0;
						lo_q    <= '0;
						hi_q    <= '0;
						rv_s1   <= 1'b0;
						status_q <= smt_pkg::ST_OK;
						lower_q  <= '0;
						upper_q  <= '0;
						ekey_q   <= '0;
						evalue_q <= '0;
						count_q  <= PW'(fill_q);
						last_q   <= 1'b1;
						case (kind)
							smt_pkg::KIND_INSERT, smt_pkg::KIND_FIND,
							smt_pkg::KIND_RANGE: state_q <= S_SCAN;
							smt_pkg::KIND_READ: begin
								if (pos_ext < fill_q && pos_ext < CW'(DEPTH_C)) begin
									idx_q   <= pos_ext;
									end_q   <= pos_ext + CW'(1);
									state_q <= S_READ;
								end else begin
									status_q    <= smt_pkg::ST_PAST_END;
									out_valid_q <= 1'b1;
									state_q     <= S_OUT;
								end
							end
							smt_pkg::KIND_CLEAR: begin
								fill_q      <= '0;
								count_q     <= '0;
								out_valid_q <= 1'b1;
								state_q     <= S_OUT;
							end
							default: begin
								out_valid_q <= 1'b1;
								state_q     <= S_OUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					// count entries below and not above the key
					if (rv_s1) begin
						if (rd_key < key_q) lo_q <= lo_q + CW'(1);
						if (rd_key <= key_q) hi_q <= hi_q + CW'(1);
					end
					if (idx_q < fill_q) begin
						idx_q <= idx_q + CW'(1);
						rv_s1 <= 1'b1;
					end else begin
						rv_s1 <= 1'b0;
						if (!rv_s1) state_q <= S_POST;
					end
				end
				S_POST: begin
					lower_q <= PW'(lo_q);
					upper_q <= PW'(hi_q);
					if (kind_q == smt_pkg::KIND_INSERT) begin
						if (fill_q == CW'(DEPTH_C)) begin
							status_q    <= smt_pkg::ST_FULL;
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							sh_q    <= fill_q;
							state_q <= (fill_q == lo_q) ? S_INS_WR : S_SHIFT_RD;
						end
					end else if (lo_q < hi_q) begin
						idx_q   <= lo_q;
						state_q <= S_READ;
						if (kind_q == smt_pkg::KIND_FIND) begin
							end_q <= lo_q + CW'(1);
						end else if (span > CW'(RES_LIMIT_C)) begin
							end_q <= lo_q + CW'(RES_LIMIT_C);
						end else begin
							end_q <= hi_q;
						end
					end else begin
						status_q    <= smt_pkg::ST_NOT_FOUND;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					// move one entry up, advance downwards
					sh_q    <= sh_q - CW'(1);
					state_q <= (sh_q - CW'(1) == lo_q) ? S_INS_WR : S_SHIFT_RD;
				end
				S_INS_WR: begin
					fill_q      <= fill_q + CW'(1);
					upper_q     <= PW'(hi_q + CW'(1));
					ekey_q      <= 32'(key_q);
					evalue_q    <= 32'(value_q);
					count_q     <= PW'(fill_q + CW'(1));
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_READ: state_q <= S_FETCH;
				S_FETCH: begin
					status_q    <= smt_pkg::ST_OK;
					ekey_q      <= 32'(rd_key);
					evalue_q    <= 32'(rd_value);
					last_q      <= (idx_q + CW'(1) == end_q);
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					// hold until the item is taken
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign lower_pos   = lower_q;
	assign upper_pos   = upper_q;
	assign entry_key   = ekey_q;
	assign entry_value = evalue_q;
	assign entry_count = count_q;
	assign last        = last_q;

endmodule

### hw/rtl/smt_checker.sv
// Port-level checks for the sorted multimap table, bound to the top level.
module smt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [1:0]                 status,
	input logic signed [31:0]         entry_key,
	input logic [31:0]                entry_value,
	input logic [smt_pkg::POS_W-1:0]  entry_count
);

	// no result may be pending while items are taken
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid) else $error("result pending while idle");

	// a taken result is not followed by another in the next cycle
	a_take_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid) else $error("result right after take");

	// full status only with a full table
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == smt_pkg::ST_FULL) |-> entry_count == 6'(smt_pkg::DEPTH))
		else $error("full reported with room left");

	// no entry on a miss
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == smt_pkg::ST_NOT_FOUND) |-> (entry_key == 0 && entry_value == 0))
		else $error("entry given on miss");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(entry_key) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind sorted_multimap_table smt_checker u_smt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.entry_key   (entry_key),
	.entry_value (entry_value),
	.entry_count (entry_count)
);
